[src/hsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared constants, types and character helpers for the host name checker.
// ----------------------------------------------------------------------------
package hsc_pkg;

	localparam int unsigned MAX_NAME_LEN_DEF = 64;
	localparam int unsigned DOT_HOST_LEN     = 5;
	localparam int unsigned CHAR_W           = 8;
	localparam int unsigned OUT_LEN_W        = 7;
	localparam int unsigned CFG_IDX_W        = 2;

	localparam logic [CHAR_W-1:0] CHR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHR_DOT   = 8'h2e;
	localparam logic [CHAR_W-1:0] CHR_HYPH  = 8'h2d;
	localparam logic [CHAR_W-1:0] CHR_QMARK = 8'h3f;

	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_QMARK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_TDOT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_DHOST = 2'd2;

	typedef struct packed {
		logic allow_question_mark;
		logic allow_trailing_dot;
		logic allow_dot_host;
	} hsc_cfg_t;

	typedef struct packed {
		logic                 name_valid;
		logic [OUT_LEN_W-1:0] name_length;
	} hsc_result_t;

	function automatic logic is_letter_or_digit(input logic [CHAR_W-1:0] c);
		return c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39]};
	endfunction

	// characters of ".host" by position
	function automatic logic [CHAR_W-1:0] dot_host_char(input logic [2:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			3'd0:    c = 8'h2e;
			3'd1:    c = 8'h68;
			3'd2:    c = 8'h6f;
			3'd3:    c = 8'h73;
			3'd4:    c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[src/hsc_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hsc_scan
// Per-name scan state and rule checks; gives the verdict on the terminator.
// ----------------------------------------------------------------------------
module hsc_scan import hsc_pkg::*; #(
	parameter int unsigned MaxNameLen = MAX_NAME_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [CHAR_W-1:0] char_in,
	input  wire hsc_cfg_t          cfg,
	output hsc_result_t            result
);

	localparam int unsigned LenSat = ((MaxNameLen + 1) > 6) ? (MaxNameLen + 1) : 6;
	localparam int unsigned LenW   = $clog2(LenSat + 1);
	localparam logic [LenW-1:0] LenSatV  = LenW'(LenSat);
	localparam logic [LenW-1:0] ShowMax  = LenW'(MaxNameLen + 1);
	localparam logic [LenW-1:0] MaxLenV  = LenW'(MaxNameLen);
	localparam logic [LenW-1:0] DotHostV = LenW'(DOT_HOST_LEN);

	logic            after_dot_q, after_hyphen_q, rule_broken_q, prefix_ok_q;
	logic [1:0]      dot_count_q;
	logic [LenW-1:0] length_q;

	logic            after_dot_d, after_hyphen_d, rule_broken_d, prefix_ok_d;
	logic [1:0]      dot_count_d;
	logic [LenW-1:0] length_d;
	logic            is_end;
	logic [LenW-1:0] shown;
	logic            valid;

	assign is_end = (char_in == CHR_NUL);

	always_comb begin
		after_dot_d    = after_dot_q;
		after_hyphen_d = after_hyphen_q;
		rule_broken_d  = rule_broken_q;
		prefix_ok_d    = prefix_ok_q;
		dot_count_d    = dot_count_q;
		length_d       = length_q;
		if (is_end) begin
			after_dot_d    = 1'b1;
			after_hyphen_d = 1'b1;
			rule_broken_d  = 1'b0;
			prefix_ok_d    = 1'b1;
			dot_count_d    = 2'd0;
			length_d       = '0;
		end else begin
			if (length_q < DotHostV) begin
				if (char_in != dot_host_char(length_q[2:0]))
					prefix_ok_d = 1'b0;
			end else begin
				prefix_ok_d = 1'b0;
			end
			if (char_in == CHR_DOT) begin
				if (after_dot_q || after_hyphen_q)
					rule_broken_d = 1'b1;
				after_dot_d    = 1'b1;
				after_hyphen_d = 1'b0;
				if (dot_count_q < 2'd2)
					dot_count_d = dot_count_q + 2'd1;
			end else if (char_in == CHR_HYPH) begin
				if (after_dot_q)
					rule_broken_d = 1'b1;
				after_dot_d    = 1'b0;
				after_hyphen_d = 1'b1;
			end else begin
				if (!is_letter_or_digit(char_in) &&
				    !(char_in == CHR_QMARK && cfg.allow_question_mark))
					rule_broken_d = 1'b1;
				after_dot_d    = 1'b0;
				after_hyphen_d = 1'b0;
			end
			if (length_q < LenSatV)
				length_d = length_q + LenW'(1);
		end
	end

	always_comb begin
		shown = (length_q > ShowMax) ? ShowMax : length_q;
		if (length_q == '0) begin
			valid = 1'b0;
		end else if (prefix_ok_q && length_q == DotHostV) begin
			valid = cfg.allow_dot_host;
		end else begin
			valid = !rule_broken_q;
			if (after_dot_q && (dot_count_q < 2'd2 || !cfg.allow_trailing_dot))
				valid = 1'b0;
			if (after_hyphen_q)
				valid = 1'b0;
			if (length_q > MaxLenV)
				valid = 1'b0;
		end
		result.name_valid  = valid;
		result.name_length = OUT_LEN_W'(shown);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_dot_q    <= 1'b1;
			after_hyphen_q <= 1'b1;
			rule_broken_q  <= 1'b0;
			prefix_ok_q    <= 1'b1;
			dot_count_q    <= 2'd0;
			length_q       <= '0;
		end else if (step) begin
			after_dot_q    <= after_dot_d;
			after_hyphen_q <= after_hyphen_d;
			rule_broken_q  <= rule_broken_d;
			prefix_ok_q    <= prefix_ok_d;
			dot_count_q    <= dot_count_d;
			length_q       <= length_d;
		end
	end

endmodule
`default_nettype wire

[src/hostname_syntax_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hostname_syntax_checker
// Streaming LDH host name syntax check, one byte per item.
// ----------------------------------------------------------------------------
// Bytes of a host name enter one per cycle; a zero byte ends the name and
// yields one result (name_valid, name_length), after which the scan state
// returns to its start. Other bytes yield no result. Each byte passes an
// input register and then one step of the rule logic; results wait in an
// output register, so the block takes one byte every cycle unless a result
// is stalled downstream; a result is registered once its zero byte leaves
// the input register. The three option bits must be written through the
// cfg port only while no name is in flight; the block does not enforce it.
module hostname_syntax_checker import hsc_pkg::*; #(
	parameter int unsigned MaxNameLen = MAX_NAME_LEN_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic [CHAR_W-1:0]    char_byte,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 name_valid,
	output      logic [OUT_LEN_W-1:0] name_length,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic                 cfg_data
);

	hsc_cfg_t          cfg_q;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              adv_s1;
	logic              out_free;
	logic              end_s1;
	hsc_result_t       result;
	hsc_result_t       result_q;

	assign cfg_ready = 1'b1;
	assign end_s1    = (char_s1 == CHR_NUL);
	assign out_free  = !out_valid || out_ready;
	assign adv_s1    = valid_s1 && (!end_s1 || out_free);
	assign in_ready  = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ALLOW_QMARK: cfg_q.allow_question_mark <= cfg_data;
				REG_ALLOW_TDOT:  cfg_q.allow_trailing_dot  <= cfg_data;
				REG_ALLOW_DHOST: cfg_q.allow_dot_host      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			char_s1 <= char_byte;
	end

	hsc_scan #(
		.MaxNameLen(MaxNameLen)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.char_in(char_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && end_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && end_s1)
			result_q <= result;
	end

	assign name_valid  = result_q.name_valid;
	assign name_length = result_q.name_length;

endmodule
`default_nettype wire
